/* sv/bmp_rs_pkg.sv */
// ----------------------------------------------------------------------------
// bmp_rs_pkg: shared types and constants of the BMP region splitter
// Record layout, queue entry layout, result kinds and header constants.
// ----------------------------------------------------------------------------
package bmp_rs_pkg;

	// Width of the internal byte position and destination offset counters.
	localparam int OFF_W = 32;
	// Width that holds a position plus one plus a whole row without overflow.
	localparam int WIDE_W = (OFF_W + 2 > 35) ? OFF_W + 2 : 35;
	// Width of a row length: three bytes per pixel of a 32-bit width.
	localparam int ROW_W = 34;

	// Result kinds.
	localparam logic [1:0] KIND_CRIT    = 2'd0;
	localparam logic [1:0] KIND_NONCRIT = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd3;

	// File and info header constants.
	localparam logic [7:0]  SIG_B        = 8'h42;
	localparam logic [7:0]  SIG_M        = 8'h4D;
	localparam logic [15:0] DEPTH_24     = 16'd24;
	localparam int          FILE_HDR_END = 13;
	localparam int          HDR_LEN      = 54;
	localparam int          HDR_END      = HDR_LEN - 1;

	// Depth of the queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// One result record, offsets already cut to 32 bits.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] src_start;
		logic [31:0] src_end;
		logic [31:0] dst_start;
		logic [31:0] dst_end;
	} rec_t;

	// A queue entry: the first record of a byte and an optional trailing
	// stop record (failure or finish), which always has zero offsets.
	typedef struct packed {
		rec_t       rec;
		logic       stop2;
		logic [1:0] stop_kind;
	} entry_t;

	// Write side of the queue.
	typedef struct packed {
		logic   push;
		entry_t ent;
	} q_wr_t;

	// Read side of the queue.
	typedef struct packed {
		logic   avail;
		entry_t ent;
	} q_rd_t;

endpackage

/* sv/bmp_rs_front.sv */
// ----------------------------------------------------------------------------
// bmp_rs_front: byte parser of the BMP region splitter
// Tracks the file position, captures the header fields and classifies each
// byte, producing at most one range record plus one stop record per beat.
// ----------------------------------------------------------------------------
module bmp_rs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [7:0]              byte_in,
	input  logic                    first_in,
	output bmp_rs_pkg::q_wr_t       q_wr
);
	import bmp_rs_pkg::*;

	// Parse phases.
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_HEADER  = 3'd1;
	localparam logic [2:0] PH_GAP     = 3'd2;
	localparam logic [2:0] PH_PIXELS  = 3'd3;
	localparam logic [2:0] PH_PADDING = 3'd4;
	localparam logic [2:0] PH_STOPPED = 3'd5;

	logic [31:0]      fs_q;
	logic [2:0]       phase_q, phase_d;
	logic [OFF_W-1:0] pos_q, pos_d;
	logic [OFF_W-1:0] crit_q, crit_d;
	logic [OFF_W-1:0] nc_q, nc_d;
	logic [OFF_W-1:0] rs_q, rs_d;
	logic [31:0]      w_q, w_d;
	logic [31:0]      h_q, h_d;
	logic [15:0]      depth_q, depth_d;
	logic [31:0]      ps_q, ps_d;
	logic [31:0]      rows_q, rows_d;
	logic [ROW_W-1:0] wcnt_q, wcnt_d;
	logic [ROW_W-1:0] rp_q;
	logic [1:0]       pad_q;
	logic [ROW_W-1:0] rt_q;
	logic [ROW_W-1:0] rp_c;

	logic             accept;
	logic [2:0]       phase;
	logic [OFF_W-1:0] pos;
	logic [OFF_W-1:0] len;
	logic [WIDE_W-1:0] pos_w1;
	logic [WIDE_W-1:0] br_next;
	logic             br_fail;
	logic             br_rows_zero;
	logic             do_br;
	logic [ROW_W-1:0] wcnt_n;
	logic [31:0]      rows_new;
	entry_t           ent;
	logic             r0_v;

	assign accept = in_valid && in_ready;

	// Row geometry follows the captured width; it settles long before the
	// first row starts, so registering it keeps the row check path short.
	assign rp_c = {2'b00, w_q} + {1'b0, w_q, 1'b0};

	always_ff @(posedge clk) begin
		rp_q  <= rp_c;
		pad_q <= 2'(2'd0 - rp_c[1:0]);
		rt_q  <= rp_q + ROW_W'(pad_q);
	end

	// Next-state and record generation for one beat.
	always_comb begin
		phase        = first_in ? PH_HEADER : phase_q;
		pos          = first_in ? '0 : pos_q;
		pos_w1       = WIDE_W'(pos) + WIDE_W'(1);
		wcnt_n       = wcnt_q + ROW_W'(1);
		rows_new     = h_q[31] ? (~h_q + 32'd1) : h_q;
		len          = '0;
		ent          = '0;
		ent.stop_kind = KIND_DONE;
		r0_v         = 1'b0;
		do_br        = 1'b0;
		br_rows_zero = 1'b0;

		if (first_in) begin
			pos_d   = '0;
			crit_d  = '0;
			nc_d    = '0;
			rs_d    = '0;
			w_d     = '0;
			h_d     = '0;
			depth_d = '0;
			ps_d    = '0;
			rows_d  = '0;
			wcnt_d  = '0;
		end else begin
			pos_d   = pos_q;
			crit_d  = crit_q;
			nc_d    = nc_q;
			rs_d    = rs_q;
			w_d     = w_q;
			h_d     = h_q;
			depth_d = depth_q;
			ps_d    = ps_q;
			rows_d  = rows_q;
			wcnt_d  = wcnt_q;
		end
		phase_d = phase;

		br_next = (phase == PH_HEADER) ? WIDE_W'(HDR_LEN) : pos_w1;
		br_fail = (br_next + WIDE_W'(rt_q)) > WIDE_W'(fs_q);

		if (phase != PH_IDLE && phase != PH_STOPPED) begin
			pos_d = pos + OFF_W'(1);
		end

		case (phase)
			PH_HEADER: begin
				// Header field capture, little-endian.
				case (pos[5:0])
					6'd10: ps_d[7:0]      = byte_in;
					6'd11: ps_d[15:8]     = byte_in;
					6'd12: ps_d[23:16]    = byte_in;
					6'd13: ps_d[31:24]    = byte_in;
					6'd18: w_d[7:0]       = byte_in;
					6'd19: w_d[15:8]      = byte_in;
					6'd20: w_d[23:16]     = byte_in;
					6'd21: w_d[31:24]     = byte_in;
					6'd22: h_d[7:0]       = byte_in;
					6'd23: h_d[15:8]      = byte_in;
					6'd24: h_d[23:16]     = byte_in;
					6'd25: h_d[31:24]     = byte_in;
					6'd28: depth_d[7:0]   = byte_in;
					6'd29: depth_d[15:8]  = byte_in;
					default: begin
					end
				endcase

				if (pos == '0) begin
					// Empty file finishes at once; bad first byte or short file fails.
					if (fs_q == 32'd0) begin
						r0_v         = 1'b1;
						ent.rec.kind = KIND_DONE;
						phase_d      = PH_STOPPED;
					end else if (byte_in != SIG_B || fs_q < 32'(HDR_LEN)) begin
						r0_v         = 1'b1;
						ent.rec.kind = KIND_FAIL;
						phase_d      = PH_STOPPED;
					end
				end else if (pos == OFF_W'(1)) begin
					if (byte_in != SIG_M) begin
						r0_v         = 1'b1;
						ent.rec.kind = KIND_FAIL;
						phase_d      = PH_STOPPED;
					end
				end else if (pos == OFF_W'(FILE_HDR_END)) begin
					r0_v              = 1'b1;
					ent.rec.kind      = KIND_CRIT;
					ent.rec.src_start = 32'd0;
					ent.rec.src_end   = 32'(FILE_HDR_END);
					ent.rec.dst_start = 32'd0;
					ent.rec.dst_end   = 32'(FILE_HDR_END);
					crit_d            = OFF_W'(FILE_HDR_END + 1);
				end else if (pos == OFF_W'(HDR_END)) begin
					r0_v              = 1'b1;
					ent.rec.kind      = KIND_CRIT;
					ent.rec.src_start = 32'(FILE_HDR_END + 1);
					ent.rec.src_end   = 32'(HDR_END);
					ent.rec.dst_start = 32'(FILE_HDR_END + 1);
					ent.rec.dst_end   = 32'(HDR_END);
					crit_d            = OFF_W'(HDR_LEN);
					// Header field checks.
					if (ps_q > fs_q || depth_q != DEPTH_24 || w_q == 32'd0 ||
						w_q[31] || h_q == 32'd0) begin
						ent.stop2     = 1'b1;
						ent.stop_kind = KIND_FAIL;
						phase_d       = PH_STOPPED;
					end else begin
						rows_d = rows_new;
						if (ps_q > 32'(HDR_LEN)) begin
							phase_d = PH_GAP;
							rs_d    = OFF_W'(HDR_LEN);
						end else begin
							do_br        = 1'b1;
							br_rows_zero = (rows_new == 32'd0);
						end
					end
				end
			end

			PH_GAP: begin
				// The gap ends on the byte before the pixel offset.
				if (pos_w1 == WIDE_W'(ps_q)) begin
					len               = pos + OFF_W'(1) - rs_q;
					r0_v              = 1'b1;
					ent.rec.kind      = KIND_CRIT;
					ent.rec.src_start = 32'(rs_q);
					ent.rec.src_end   = 32'(pos);
					ent.rec.dst_start = 32'(crit_q);
					ent.rec.dst_end   = 32'(crit_q + len - OFF_W'(1));
					crit_d            = crit_q + len;
					do_br             = 1'b1;
					br_rows_zero      = (rows_q == 32'd0);
				end
			end

			PH_PIXELS: begin
				wcnt_d = wcnt_n;
				if (wcnt_n == rp_q) begin
					len               = OFF_W'(rp_q);
					r0_v              = 1'b1;
					ent.rec.kind      = KIND_NONCRIT;
					ent.rec.src_start = 32'(rs_q);
					ent.rec.src_end   = 32'(pos);
					ent.rec.dst_start = 32'(nc_q);
					ent.rec.dst_end   = 32'(nc_q + len - OFF_W'(1));
					nc_d              = nc_q + len;
					if (pad_q != 2'd0) begin
						phase_d = PH_PADDING;
						rs_d    = pos + OFF_W'(1);
						wcnt_d  = '0;
					end else begin
						rows_d       = rows_q - 32'd1;
						do_br        = 1'b1;
						br_rows_zero = (rows_q == 32'd1);
					end
				end
			end

			PH_PADDING: begin
				wcnt_d = wcnt_n;
				if (wcnt_n == ROW_W'(pad_q)) begin
					len               = OFF_W'(pad_q);
					r0_v              = 1'b1;
					ent.rec.kind      = KIND_CRIT;
					ent.rec.src_start = 32'(rs_q);
					ent.rec.src_end   = 32'(pos);
					ent.rec.dst_start = 32'(crit_q);
					ent.rec.dst_end   = 32'(crit_q + len - OFF_W'(1));
					crit_d            = crit_q + len;
					rows_d            = rows_q - 32'd1;
					do_br             = 1'b1;
					br_rows_zero      = (rows_q == 32'd1);
				end
			end

			default: begin
			end
		endcase

		// Start of the next row: finish, failure on overrun, or pixels.
		if (do_br) begin
			if (br_rows_zero) begin
				ent.stop2     = 1'b1;
				ent.stop_kind = KIND_DONE;
				phase_d       = PH_STOPPED;
			end else if (br_fail) begin
				ent.stop2     = 1'b1;
				ent.stop_kind = KIND_FAIL;
				phase_d       = PH_STOPPED;
			end else begin
				phase_d = PH_PIXELS;
				rs_d    = OFF_W'(br_next);
				wcnt_d  = '0;
			end
		end
	end

	assign q_wr.push = accept && r0_v;
	assign q_wr.ent  = ent;

	// File size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= '0;
		end else if (cfg_we) begin
			fs_q <= cfg_wdata;
		end
	end

	// Parser state, updated on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			crit_q  <= '0;
			nc_q    <= '0;
			rs_q    <= '0;
			w_q     <= '0;
			h_q     <= '0;
			depth_q <= '0;
			ps_q    <= '0;
			rows_q  <= '0;
			wcnt_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			crit_q  <= crit_d;
			nc_q    <= nc_d;
			rs_q    <= rs_d;
			w_q     <= w_d;
			h_q     <= h_d;
			depth_q <= depth_d;
			ps_q    <= ps_d;
			rows_q  <= rows_d;
			wcnt_q  <= wcnt_d;
		end
	end

endmodule

/* sv/bmp_rs_fifo.sv */
// ----------------------------------------------------------------------------
// bmp_rs_fifo: record queue of the BMP region splitter
// A short queue of entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module bmp_rs_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  bmp_rs_pkg::q_wr_t wr,
	input  logic              pop,
	output bmp_rs_pkg::q_rd_t rd,
	output logic              full
);
	import bmp_rs_pkg::*;

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_pop;

	assign full     = (cnt_q == (QPTR_W + 1)'(QDEPTH));
	assign rd.avail = (cnt_q != '0);
	assign rd.ent   = mem_q[rptr_q];
	assign do_pop   = pop && rd.avail;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wptr_q] <= wr.ent;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr.push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (wr.push && !do_pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !wr.push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

/* sv/bmp_rs_back.sv */
// ----------------------------------------------------------------------------
// bmp_rs_back: output stage of the BMP region splitter
// Unpacks queue entries into single records and holds them in an output
// register until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module bmp_rs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bmp_rs_pkg::q_rd_t rd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output bmp_rs_pkg::rec_t  out_rec,
	output logic              out_last
);
	import bmp_rs_pkg::*;

	logic out_valid_q;
	rec_t out_rec_q;
	logic out_last_q;
	logic sub_q;
	logic load;
	rec_t nxt_rec;
	logic nxt_last;

	assign load = rd.avail && (!out_valid_q || out_ready);

	// Pick the record of the head entry that goes out next.
	always_comb begin
		if (sub_q) begin
			nxt_rec      = '0;
			nxt_rec.kind = rd.ent.stop_kind;
			nxt_last     = 1'b1;
		end else begin
			nxt_rec  = rd.ent.rec;
			nxt_last = !rd.ent.stop2;
		end
	end

	// The entry leaves the queue with its final record.
	assign pop = load && nxt_last;

	always_ff @(posedge clk) begin
		if (load) begin
			out_rec_q  <= nxt_rec;
			out_last_q <= nxt_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= !nxt_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_rec_q;
	assign out_last  = out_last_q;

endmodule

/* sv/bmp_region_splitter.sv */
// ----------------------------------------------------------------------------
// A result beat passes through the queue and then the output register before it appears.
// Throughput: one input byte per cycle while the queue is not full; a byte that yields
// two records sends them as two output beats, absorbed by a four-entry queue.
// The byte rate is set by the parser's single row-fit add and compare.
// Reset: arst_n clears the parser to idle, file_size to zero, and empties the
// queue and output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// bmp_region_splitter: 24-bit BMP critical/non-critical region splitter
// Parses a BMP file byte by byte and emits range records for header, gap,
// padding and pixel regions, plus failure or finish reports.
// ----------------------------------------------------------------------------
module bmp_region_splitter (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,      // file_size
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,        // byte_value
	input  logic [0:0]   s_tuser,        // first_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,        // source_start, source_end, dest_start, dest_end
	output logic [1:0]   m_tuser,        // result_kind
	output logic         m_tlast         // last_of_run
);
	import bmp_rs_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  q_pop;
	rec_t  out_rec;

	assign s_tready = !q_full;

	// Parser front.
	bmp_rs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.byte_in   (s_tdata),
		.first_in  (s_tuser[0]),
		.q_wr      (q_wr)
	);

	// Queue between the two sides.
	bmp_rs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd),
		.full   (q_full)
	);

	// Output back end.
	bmp_rs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (q_rd),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (out_rec),
		.out_last  (m_tlast)
	);

	assign m_tdata = {out_rec.dst_end, out_rec.dst_start, out_rec.src_end, out_rec.src_start};
	assign m_tuser = out_rec.kind;

endmodule

/* sv/bmp_rs_checker.sv */
// ----------------------------------------------------------------------------
// bmp_rs_checker: port-level checks of the BMP region splitter
// Watches the result stream for stalls, record shape and record pairing.
// ----------------------------------------------------------------------------
module bmp_rs_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);
	import bmp_rs_pkg::*;

	// A stalled result beat holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// Failure and finish reports carry zero offsets and close the byte's run.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_FAIL || m_tuser == KIND_DONE) |->
		m_tdata == '0 && m_tlast)
		else $error("stop report with offsets or without last");

	// A range spans as many bytes in the destination as in the source.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |->
		32'(m_tdata[63:32] - m_tdata[31:0]) == 32'(m_tdata[127:96] - m_tdata[95:64]))
		else $error("range source and destination lengths differ");

	// Only a range can be followed by a second record of the same byte,
	// and that record is a stop report shown in the very next cycle.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |->
		!m_tuser[1] ##1 (m_tvalid && m_tuser[1]))
		else $error("range record not followed by its stop report");

endmodule

bind bmp_region_splitter bmp_rs_checker u_bmp_rs_checker (.*);

/* bench/bmp_region_splitter_tb.sv */
// ----------------------------------------------------------------------------
// bmp_region_splitter_tb: self-checking bench for the BMP region splitter
// Streams whole and broken BMP files into the splitter, one byte per beat, under
// random sender gaps and receiver stalls, predicts every range, failure and
// finish record in step with the parser, and compares each result beat field
// by field against the oldest record still awaited.
// ----------------------------------------------------------------------------
module bmp_region_splitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bmp_rs_pkg::*;

	localparam int RESET_CYCLES   = 5;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int OUTPUT_HOLD    = 150;
	localparam int RANDOM_BYTES   = 40;
	localparam int RANDOM_REGIONS = 4;

	// Parser phases of the prediction.
	typedef enum logic [2:0] {
		PARSE_IDLE, PARSE_HDR, PARSE_GAP, PARSE_ROW, PARSE_PAD, PARSE_HALT
	} parse_state_t;

	// Receiver ready patterns.
	typedef enum logic [1:0] {RX_STREAM, RX_CHOPPY, RX_SPARSE} rx_mode_t;

	// One predicted result beat.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] src_start;
		logic [31:0] src_end;
		logic [31:0] dst_start;
		logic [31:0] dst_end;
		logic        last;
	} region_t;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         cfg_we    = 1'b0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata   = '0;       // byte_value
	logic [0:0]   s_tuser   = '0;       // first_byte
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [127:0] m_tdata;              // source_start, source_end, dest_start, dest_end
	logic [1:0]   m_tuser;              // result_kind
	logic         m_tlast;              // last_of_run

	bmp_region_splitter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Records still awaited, oldest first, and the records of the current byte.
	region_t pending_regions[$];
	region_t step_regions[$];
	int      err_count    = 0;
	int      live_bytes   = 0;
	int      region_count = 0;
	int      burst_left   = 0;
	int      stall_request = 0;
	logic [7:0] file_img[$];

	// Parser state as predicted, plus the file size register.
	logic [31:0]  model_file_size = '0;
	logic [31:0]  next_pos        = '0;
	logic [31:0]  crit_off        = '0;
	logic [31:0]  noncrit_off     = '0;
	logic [63:0]  run_start       = '0;
	logic [63:0]  run_count       = '0;
	logic [31:0]  img_width       = '0;
	logic [31:0]  img_height      = '0;
	logic [15:0]  img_depth       = '0;
	logic [31:0]  pix_offset      = '0;
	logic [31:0]  rows_todo       = '0;
	parse_state_t parse_state     = PARSE_IDLE;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	function automatic logic [63:0] row_data_bytes();
		return {32'd0, img_width} * 64'd3;
	endfunction

	// Rows are padded to a multiple of four bytes.
	function automatic logic [63:0] row_stride();
		return (row_data_bytes() + 64'd3) & ~64'd3;
	endfunction

	function automatic void note_region(input logic [1:0] kind, input logic [63:0] src_lo,
			input logic [63:0] src_hi, input logic [63:0] dst_lo, input logic [63:0] dst_hi);
		region_t r;
		r.kind      = kind;
		r.src_start = src_lo[31:0];
		r.src_end   = src_hi[31:0];
		r.dst_start = dst_lo[31:0];
		r.dst_end   = dst_hi[31:0];
		r.last      = 1'b0;
		step_regions.push_back(r);
	endfunction

	function automatic void halt_file(input logic [1:0] kind);
		parse_state = PARSE_HALT;
		note_region(kind, 64'd0, 64'd0, 64'd0, 64'd0);
	endfunction

	// Start the next row at the given offset, or end the file.
	function automatic void next_row(input logic [63:0] at);
		if (rows_todo == 0) begin
			halt_file(KIND_DONE);
		end else if (at + row_stride() > {32'd0, model_file_size}) begin
			halt_file(KIND_FAIL);
		end else begin
			parse_state = PARSE_ROW;
			run_start   = at;
			run_count   = '0;
		end
	endfunction

	// One byte of the 54 header bytes.
	function automatic void header_step(input logic [63:0] pos, input logic [7:0] data_byte);
		if (pos == 0) begin
			if (model_file_size == 0) begin
				halt_file(KIND_DONE);
				return;
			end
			if (data_byte != SIG_B || model_file_size < HDR_LEN) begin
				halt_file(KIND_FAIL);
				return;
			end
		end
		if (pos == 1 && data_byte != SIG_M) begin
			halt_file(KIND_FAIL);
			return;
		end
		if (pos >= 10 && pos <= 13)
			pix_offset |= {24'd0, data_byte} << (8 * (pos - 10));
		if (pos >= 18 && pos <= 21)
			img_width |= {24'd0, data_byte} << (8 * (pos - 18));
		if (pos >= 22 && pos <= 25)
			img_height |= {24'd0, data_byte} << (8 * (pos - 22));
		if (pos >= 28 && pos <= 29)
			img_depth |= {8'd0, data_byte} << (8 * (pos - 28));
		if (pos == FILE_HDR_END) begin
			note_region(KIND_CRIT, 64'd0, 64'(FILE_HDR_END), 64'd0, 64'(FILE_HDR_END));
			crit_off = FILE_HDR_END + 1;
		end
		if (pos == HDR_END) begin
			note_region(KIND_CRIT, 64'(FILE_HDR_END + 1), 64'(HDR_END),
				64'(FILE_HDR_END + 1), 64'(HDR_END));
			crit_off = HDR_LEN;
			if (pix_offset > model_file_size || img_depth != DEPTH_24 || img_width == 0 ||
					img_width[31] || img_height == 0) begin
				halt_file(KIND_FAIL);
				return;
			end
			// A negative height only flips the row order.
			rows_todo = img_height[31] ? -img_height : img_height;
			if (pix_offset > HDR_LEN) begin
				parse_state = PARSE_GAP;
				run_start   = 64'(HDR_LEN);
			end else begin
				next_row(64'(HDR_LEN));
			end
		end
	endfunction

	// Work out the records caused by one accepted byte and queue them.
	function automatic void predict_regions(input logic [7:0] data_byte, input logic first);
		logic [63:0] pos;
		logic [63:0] len;
		step_regions.delete();
		if (first) begin
			next_pos    = '0;
			crit_off    = '0;
			noncrit_off = '0;
			run_start   = '0;
			run_count   = '0;
			img_width   = '0;
			img_height  = '0;
			img_depth   = '0;
			pix_offset  = '0;
			rows_todo   = '0;
			parse_state = PARSE_HDR;
		end
		if (parse_state == PARSE_IDLE || parse_state == PARSE_HALT)
			return;
		live_bytes++;
		pos      = {32'd0, next_pos};
		next_pos = next_pos + 32'd1;

		case (parse_state)
			PARSE_HDR: begin
				header_step(pos, data_byte);
			end
			PARSE_GAP: begin
				if (pos + 1 == {32'd0, pix_offset}) begin
					len = pos + 1 - run_start;
					note_region(KIND_CRIT, run_start, pos, {32'd0, crit_off},
						{32'd0, crit_off} + len - 1);
					crit_off = crit_off + len[31:0];
					next_row(pos + 1);
				end
			end
			PARSE_ROW: begin
				run_count++;
				if (run_count >= row_data_bytes()) begin
					len = row_data_bytes();
					note_region(KIND_NONCRIT, run_start, pos, {32'd0, noncrit_off},
						{32'd0, noncrit_off} + len - 1);
					noncrit_off = noncrit_off + len[31:0];
					if (row_stride() > len) begin
						parse_state = PARSE_PAD;
						run_start   = pos + 1;
						run_count   = '0;
					end else begin
						rows_todo--;
						next_row(pos + 1);
					end
				end
			end
			PARSE_PAD: begin
				run_count++;
				len = row_stride() - row_data_bytes();
				if (run_count >= len) begin
					note_region(KIND_CRIT, run_start, pos, {32'd0, crit_off},
						{32'd0, crit_off} + len - 1);
					crit_off = crit_off + len[31:0];
					rows_todo--;
					next_row(pos + 1);
				end
			end
			default: begin
			end
		endcase

		if (step_regions.size() > 0)
			step_regions[$].last = 1'b1;
		foreach (step_regions[i])
			pending_regions.push_back(step_regions[i]);
		region_count += step_regions.size();
	endfunction

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		region_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_regions.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result beat, expected none, got kind %0d data %0h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending_regions.pop_front();
				check_field("result_kind", 32'(want.kind), 32'(m_tuser));
				check_field("source_start", want.src_start, m_tdata[31:0]);
				check_field("source_end", want.src_end, m_tdata[63:32]);
				check_field("dest_start", want.dst_start, m_tdata[95:64]);
				check_field("dest_end", want.dst_end, m_tdata[127:96]);
				check_field("last_of_run", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: patterned stalls, plus a long hold-off on request
	// ------------------------------------------------------------------------

	int       hold_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode   = RX_STREAM;

	always @(negedge clk) begin
		if (stall_request != 0) begin
			hold_left     = stall_request;
			stall_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(4, 40);
			end
			mode_left--;
			case (rx_mode)
				RX_STREAM: m_tready <= 1'b1;
				RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
				default:   m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends the run when no beat moves for too long
	// ------------------------------------------------------------------------

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Send one byte; the sender works in bursts with random gaps between them.
	task automatic send_byte(input logic [7:0] value, input logic first);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= first;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		predict_regions(value, first);
	endtask

	// Write file_size once every awaited record is out and the pipeline is empty.
	task automatic write_file_size(input logic [31:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_regions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_file_size = value;
	endtask

	function automatic void put_word(input int at, input logic [31:0] value);
		for (int k = 0; k < 4; k++)
			file_img[at + k] = value[8 * k +: 8];
	endfunction

	// Build a file image: random header filler, the given fields, random body.
	function automatic void make_bmp(input logic [31:0] pix_off, input logic [31:0] width,
			input logic [31:0] height, input logic [15:0] depth, input int body_len);
		file_img.delete();
		for (int i = 0; i < HDR_LEN + body_len; i++)
			file_img.push_back(8'($urandom_range(0, 255)));
		file_img[0] = SIG_B;
		file_img[1] = SIG_M;
		put_word(10, pix_off);
		put_word(18, width);
		put_word(22, height);
		file_img[28] = depth[7:0];
		file_img[29] = depth[15:8];
	endfunction

	// Length of a well-formed file with this geometry.
	function automatic logic [63:0] image_bytes(input logic [31:0] pix_off,
			input logic [31:0] width, input logic [31:0] height);
		logic [63:0] rows;
		logic [63:0] stride;
		logic [63:0] lead;
		rows   = height[31] ? {32'd0, -height} : {32'd0, height};
		stride = (({32'd0, width} * 64'd3) + 64'd3) & ~64'd3;
		lead   = (pix_off > HDR_LEN) ? {32'd0, pix_off} : 64'(HDR_LEN);
		return lead + rows * stride;
	endfunction

	task automatic stream_file(input int count);
		for (int i = 0; i < count; i++)
			send_byte(file_img[i], i == 0);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Bytes before any file has started give nothing.
	task automatic test_idle_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(SIG_B, 1'b0);
	endtask

	// Empty file, short file, and a bad signature at either byte.
	task automatic test_signatures();
		write_file_size(32'd0);
		send_byte(SIG_B, 1'b1);
		send_byte(8'hA5, 1'b0);
		write_file_size(HDR_LEN - 1);
		send_byte(SIG_B, 1'b1);
		write_file_size(HDR_LEN);
		send_byte(8'h41, 1'b1);
		send_byte(SIG_B, 1'b1);
		send_byte(8'h4E, 1'b0);
		send_byte(SIG_M, 1'b0);
	endtask

	// Each header defect fails right after the info header record.
	task automatic test_header_defects();
		write_file_size(32'd200);
		make_bmp(32'd201, 32'd2, 32'd1, DEPTH_24, 0);
		stream_file(HDR_LEN);
		make_bmp(HDR_LEN, 32'd2, 32'd1, 16'd32, 0);
		stream_file(HDR_LEN);
		make_bmp(HDR_LEN, 32'd0, 32'd1, DEPTH_24, 0);
		stream_file(HDR_LEN);
		make_bmp(HDR_LEN, 32'h8000_0000, 32'd1, DEPTH_24, 0);
		stream_file(HDR_LEN);
		make_bmp(HDR_LEN, 32'd2, 32'd0, DEPTH_24, 0);
		stream_file(HDR_LEN);
		// A huge width must not wrap the row size, even with the largest file.
		write_file_size(32'hFFFF_FFFF);
		make_bmp(HDR_LEN, 32'h7FFF_FFFF, 32'd1, DEPTH_24, 0);
		stream_file(HDR_LEN);
	endtask

	task automatic test_pixel_layouts();
		// Gap before the pixels, padded rows, height stored as negative.
		make_bmp(32'd60, 32'd1, -32'sd2, DEPTH_24, 14);
		write_file_size(32'd68);
		stream_file(68);
		// Pixel offset inside the headers, unpadded row, trailing bytes ignored.
		make_bmp(32'd10, 32'd4, 32'd1, DEPTH_24, 15);
		write_file_size(32'd69);
		stream_file(69);
		// Pixels right after the headers; the second row does not fit.
		make_bmp(HDR_LEN, 32'd3, 32'd2, DEPTH_24, 17);
		write_file_size(32'd71);
		stream_file(71);
	endtask

	// Receiver holds off while many narrow rows keep results coming.
	task automatic test_output_stall();
		make_bmp(32'd0, 32'd1, 32'd10, DEPTH_24, 40);
		write_file_size(32'd94);
		stall_request = OUTPUT_HOLD;
		stream_file(94);
	endtask

	// Mostly well-formed files with random geometry and content; the rest are
	// truncated and restarted, or carry a defect.
	task automatic test_random_files();
		int          base_live;
		int          base_regions;
		int          choice;
		int          rows;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] pix_off;
		logic [31:0] fsize;
		logic [15:0] depth;
		logic [63:0] need;
		base_live    = live_bytes;
		base_regions = region_count;
		while (live_bytes - base_live < RANDOM_BYTES ||
				region_count - base_regions < RANDOM_REGIONS) begin
			width  = $urandom_range(1, 5);
			rows   = $urandom_range(1, 3);
			height = rows;
			if ($urandom_range(0, 1))
				height = -height;
			case ($urandom_range(0, 3))
				0:       pix_off = $urandom_range(0, HDR_LEN - 1);
				1:       pix_off = HDR_LEN;
				default: pix_off = $urandom_range(HDR_LEN + 1, 80);
			endcase
			depth  = DEPTH_24;
			need   = image_bytes(pix_off, width, height);
			fsize  = need[31:0];
			choice = $urandom_range(0, 99);
			if (choice < 60) begin
				// Whole file, sometimes with trailing bytes.
				if ($urandom_range(0, 3) == 0)
					fsize = fsize + $urandom_range(1, 6);
				make_bmp(pix_off, width, height, depth, int'(fsize) - HDR_LEN);
				write_file_size(fsize);
				stream_file(int'(fsize));
			end else if (choice < 75) begin
				// Cut short, then restarted mid-file by a fresh image.
				make_bmp(pix_off, width, height, depth, int'(fsize) - HDR_LEN);
				write_file_size(fsize);
				stream_file($urandom_range(1, int'(fsize) - 1));
				make_bmp(pix_off, width, height, depth, int'(fsize) - HDR_LEN);
				stream_file(int'(fsize));
			end else if (choice < 90) begin
				case ($urandom_range(0, 5))
					0: begin
						depth = 16'($urandom_range(0, 65535));
						if (depth == DEPTH_24)
							depth = ~depth;
					end
					1: width = '0;
					2: width = $urandom | 32'h8000_0000;
					3: height = '0;
					4: pix_off = fsize + $urandom_range(1, 300);
					default: fsize = fsize - $urandom_range(1, 4);
				endcase
				make_bmp(pix_off, width, height, depth, int'(fsize) - HDR_LEN);
				write_file_size(fsize);
				stream_file(int'(fsize));
			end else begin
				make_bmp(pix_off, width, height, depth, 0);
				case ($urandom_range(0, 3))
					0: file_img[0] = SIG_B ^ 8'($urandom_range(1, 255));
					1: file_img[1] = SIG_M ^ 8'($urandom_range(1, 255));
					2: fsize = $urandom_range(1, HDR_LEN - 1);
					default: fsize = '0;
				endcase
				write_file_size(fsize);
				stream_file(3);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_idle_bytes();
		test_signatures();
		test_header_defects();
		test_pixel_layouts();
		test_output_stall();
		test_random_files();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_regions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_regions.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
